@@ rtl/spf_pkg.sv @@
`default_nettype none

package spf_pkg;

	// field and register widths
	localparam int SAMPLE_W = 16;
	localparam int LENGTH_BITS = 24;
	localparam int GAIN_W = 15;
	localparam int COLS_W = 11;
	localparam int COL_W = 10;
	localparam int LEVEL_W = 8;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = LENGTH_BITS;

	// fade, gain and envelope limits
	localparam int FADE_SAMPLES = 128;
	localparam int FADE_W = $clog2(FADE_SAMPLES + 1);
	localparam int MAX_COLUMNS = 1024;
	localparam int GAIN_MAX_Q12 = 16384;
	localparam int GW_W = GAIN_W + FADE_W;

	// filter arithmetic
	localparam int HP_FRAC = 15;
	localparam int HP_COEF_Q15 = 31752;
	localparam int STATE_W = 32;
	localparam int DIFF_W = STATE_W + 1;
	localparam int COMP_W = STATE_W + 4;
	localparam int NUM_W = COMP_W + GW_W + 1;
	localparam int SCALE_SHIFT = 29 + $clog2(FADE_SAMPLES);

	// column stepping
	localparam int STEP_W = LENGTH_BITS + 1;

	// request queue between front and back
	localparam int QUEUE_DEPTH = 4;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_GAIN = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LENGTH = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_COLUMNS = 2'd2;

	// effective configuration after clamping
	typedef struct packed {
		logic [GAIN_W-1:0] gain;
		logic [LENGTH_BITS-1:0] len;
		logic [COLS_W-1:0] cols;
	} spf_cfg_t;

	// one classified request
	typedef struct packed {
		logic signed [SAMPLE_W-1:0] sample;
		logic first;
		logic filt;
		logic [FADE_W-1:0] weight;
		logic eot;
	} spf_item_t;

endpackage

`default_nettype wire

@@ rtl/spf_front.sv @@
`default_nettype none

module spf_front
	import spf_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_stall,
	input wire logic signed [SAMPLE_W-1:0] sample,
	input wire logic first,
	input wire spf_cfg_t cfg,
	input wire logic q_full,
	output logic push,
	output spf_item_t push_item
);

	localparam logic [LENGTH_BITS-1:0] IDX_MAX = '1;
	localparam logic [LENGTH_BITS-1:0] FADE_LEN = LENGTH_BITS'(FADE_SAMPLES);
	localparam logic [LENGTH_BITS-1:0] FILT_MIN = LENGTH_BITS'(2 * FADE_SAMPLES);

	logic [LENGTH_BITS-1:0] idx_q;
	logic [LENGTH_BITS-1:0] idx;
	logic [LENGTH_BITS-1:0] len_m1;
	logic [LENGTH_BITS-1:0] fade_end;
	logic [FADE_W-1:0] weight;

	assign in_stall = q_full;
	assign push = in_valid && !q_full;

	// sample position within the take, restarted by the first mark
	assign idx = first ? '0 : idx_q;
	assign len_m1 = cfg.len - 1'b1;
	assign fade_end = cfg.len - FADE_LEN;

	// fade weight: ramp up, flat, ramp down, zero past the end
	always_comb begin
		if (idx >= cfg.len) begin
			weight = '0;
		end else if (idx < FADE_LEN) begin
			weight = idx[FADE_W-1:0];
		end else if (idx >= fade_end) begin
			weight = FADE_W'(cfg.len - idx);
		end else begin
			weight = FADE_W'(FADE_SAMPLES);
		end
	end

	// classified request
	always_comb begin
		push_item.sample = sample;
		push_item.first = first;
		push_item.filt = cfg.len >= FILT_MIN;
		push_item.weight = weight;
		push_item.eot = idx == len_m1;
	end

	// saturating sample counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
		end else if (push) begin
			idx_q <= (idx != IDX_MAX) ? idx + 1'b1 : idx;
		end
	end

endmodule

`default_nettype wire

@@ rtl/spf_queue.sv @@
`default_nettype none

module spf_queue
	import spf_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire logic push,
	input wire spf_item_t push_item,
	input wire logic pop,
	output logic full,
	output logic empty,
	output spf_item_t head
);

	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	spf_item_t mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_q;
	logic [PTR_W-1:0] rd_q;
	logic [CNT_W-1:0] cnt_q;

	assign full = cnt_q == CNT_W'(QUEUE_DEPTH);
	assign empty = cnt_q == '0;
	assign head = mem_q[rd_q];

	// entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_item;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= rd_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

@@ rtl/spf_div.sv @@
`default_nettype none

module spf_div
	import spf_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	input wire logic [STEP_W-1:0] dividend,
	input wire logic [LENGTH_BITS-1:0] divisor,
	output logic busy,
	output logic [STEP_W-1:0] quotient,
	output logic [LENGTH_BITS-1:0] remainder
);

	localparam int CNT_W = $clog2(STEP_W + 1);

	logic [CNT_W-1:0] cnt_q;
	logic [STEP_W-1:0] quo_q;
	logic [LENGTH_BITS-1:0] rem_q;
	logic [LENGTH_BITS-1:0] dsr_q;
	logic [LENGTH_BITS:0] trial;
	logic fits;

	assign busy = cnt_q != '0;
	assign quotient = quo_q;
	assign remainder = rem_q;

	// restoring step: one quotient bit per cycle
	assign trial = {rem_q, quo_q[STEP_W-1]};
	assign fits = trial >= {1'b0, dsr_q};

	// iteration counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= CNT_W'(STEP_W);
		end else if (busy) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	// partial remainder and quotient shift register
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dsr_q <= divisor;
		end else if (busy) begin
			quo_q <= {quo_q[STEP_W-2:0], fits};
			rem_q <= fits ? LENGTH_BITS'(trial - {1'b0, dsr_q}) : trial[LENGTH_BITS-1:0];
		end
	end

endmodule

`default_nettype wire

@@ rtl/spf_back.sv @@
`default_nettype none

module spf_back
	import spf_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire spf_cfg_t cfg,
	input wire logic q_empty,
	input wire spf_item_t head,
	output logic pop,
	output logic out_valid,
	input wire logic out_stall,
	output logic signed [SAMPLE_W-1:0] out_sample,
	output logic [COL_W-1:0] env_column,
	output logic [LEVEL_W-1:0] env_level,
	output logic end_of_take
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_HP,
		ST_COMP,
		ST_SCALE,
		ST_ROUND,
		ST_ENV,
		ST_DIV,
		ST_FIN
	} state_t;

	localparam int HP_COEF_W = HP_FRAC + 2;
	localparam int HP_PROD_W = DIFF_W + HP_COEF_W;
	localparam int HP_SH_W = HP_PROD_W - HP_FRAC;
	localparam logic signed [HP_COEF_W-1:0] HP_COEF = HP_COEF_W'(HP_COEF_Q15);
	localparam logic signed [HP_PROD_W-1:0] HP_HALF = HP_PROD_W'(1 << (HP_FRAC - 1));
	localparam int QF_W = NUM_W - SCALE_SHIFT;
	localparam int QR_W = QF_W + 1;

	state_t state_q;
	logic out_valid_q;
	logic signed [SAMPLE_W-1:0] out_sample_q;
	logic [COL_W-1:0] env_column_q;
	logic [LEVEL_W-1:0] env_level_q;
	logic end_of_take_q;

	// filter and envelope state
	logic signed [SAMPLE_W-1:0] prev_in_q;
	logic signed [STATE_W-1:0] prev_out_q;
	logic signed [STATE_W-1:0] d1_q;
	logic signed [STATE_W-1:0] d2_q;
	logic primed_q;
	logic [COL_W-1:0] col_q;
	logic [LENGTH_BITS-1:0] rem_q;
	logic [LEVEL_W-1:0] peak_q;

	// working registers of one request
	logic signed [DIFF_W-1:0] diff_q;
	logic [GW_W-1:0] gw_q;
	logic signed [STATE_W-1:0] y_q;
	logic signed [COMP_W-1:0] comp_q;
	logic signed [NUM_W-1:0] num_q;
	logic signed [SAMPLE_W-1:0] res_q;
	logic eot_q;
	logic [COL_W-1:0] ci_q;
	logic [LEVEL_W-1:0] pk_q;

	logic prim_eff;
	logic signed [SAMPLE_W-1:0] pin;
	logic signed [STATE_W-1:0] pout;
	logic signed [DIFF_W-1:0] diff;
	logic [GW_W-1:0] gw;
	logic signed [HP_PROD_W-1:0] hp_full;
	logic signed [HP_SH_W-1:0] hp_sh;
	logic signed [STATE_W-1:0] y_sat;
	logic signed [COMP_W-1:0] comp;
	logic signed [NUM_W-1:0] num;
	logic signed [QF_W-1:0] q_fl;
	logic rnd_up;
	logic signed [QR_W-1:0] q_rnd;
	logic signed [SAMPLE_W-1:0] res_sat;

	logic cols_on;
	logic [COL_W-1:0] cols_m1;
	logic [COL_W-1:0] ci;
	logic signed [SAMPLE_W:0] rx;
	logic [SAMPLE_W:0] mag;
	logic [LEVEL_W-1:0] lvl_new;
	logic [LEVEL_W-1:0] pk;
	logic [STEP_W-1:0] step;
	logic [STEP_W-1:0] len_x;
	logic [STEP_W-1:0] step_m;
	logic fast0;
	logic fast;
	logic [STEP_W-1:0] fq;
	logic [LENGTH_BITS-1:0] fr;
	logic [STEP_W-1:0] q_sel;
	logic [LENGTH_BITS-1:0] r_sel;
	logic [COL_W-1:0] ci_sel;
	logic [LEVEL_W-1:0] pk_sel;
	logic [STEP_W:0] nsum;
	logic [COL_W-1:0] nxt;
	logic slot_free;
	logic commit;
	logic env_upd;
	logic div_start;
	logic div_busy;
	logic [STEP_W-1:0] div_quo;
	logic [LENGTH_BITS-1:0] div_rem;

	assign out_valid = out_valid_q;
	assign out_sample = out_sample_q;
	assign env_column = env_column_q;
	assign env_level = env_level_q;
	assign end_of_take = end_of_take_q;

	assign pop = (state_q == ST_IDLE) && !q_empty;

	// filter input difference, with restart and seeding on the first sample
	assign prim_eff = !head.first && primed_q;
	assign pin = prim_eff ? prev_in_q : head.sample;
	assign pout = head.first ? '0 : prev_out_q;
	assign diff = DIFF_W'(pout)
		+ ((DIFF_W'(head.sample) - DIFF_W'(pin)) <<< HP_FRAC);
	assign gw = GW_W'(cfg.gain) * GW_W'(head.weight);

	// one-pole high-pass: multiply, round half up, saturate to 32 bits
	assign hp_full = diff_q * HP_COEF + HP_HALF;
	assign hp_sh = hp_full[HP_PROD_W-1:HP_FRAC];
	always_comb begin
		if (hp_sh[HP_SH_W-1:STATE_W-1] == '0 || hp_sh[HP_SH_W-1:STATE_W-1] == '1) begin
			y_sat = hp_sh[STATE_W-1:0];
		end else if (hp_sh[HP_SH_W-1]) begin
			y_sat = {1'b1, {(STATE_W-1){1'b0}}};
		end else begin
			y_sat = {1'b0, {(STATE_W-1){1'b1}}};
		end
	end

	// droop compensator taps
	assign comp = (COMP_W'(d1_q) <<< 2) + (COMP_W'(d1_q) <<< 1)
		- (COMP_W'(y_q) + COMP_W'(d2_q));

	// gain and fade scaling
	assign num = comp_q * $signed({1'b0, gw_q});

	// round half to even, saturate to 16 bits
	assign q_fl = num_q[NUM_W-1:SCALE_SHIFT];
	assign rnd_up = num_q[SCALE_SHIFT-1] && ((num_q[SCALE_SHIFT-2:0] != '0) || q_fl[0]);
	assign q_rnd = QR_W'(q_fl) + QR_W'(rnd_up);
	always_comb begin
		if (q_rnd[QR_W-1:SAMPLE_W-1] == '0 || q_rnd[QR_W-1:SAMPLE_W-1] == '1) begin
			res_sat = q_rnd[SAMPLE_W-1:0];
		end else if (q_rnd[QR_W-1]) begin
			res_sat = {1'b1, {(SAMPLE_W-1){1'b0}}};
		end else begin
			res_sat = {1'b0, {(SAMPLE_W-1){1'b1}}};
		end
	end

	// envelope column and peak of the current sample, full-scale magnitude clips to 255
	assign cols_on = cfg.cols != '0;
	assign cols_m1 = COL_W'(cfg.cols - 1'b1);
	assign ci = (col_q > cols_m1) ? cols_m1 : col_q;
	assign rx = (SAMPLE_W+1)'(res_q);
	assign mag = rx[SAMPLE_W] ? (SAMPLE_W+1)'(-rx) : rx;
	assign lvl_new = (mag[SAMPLE_W:SAMPLE_W-1] != '0) ? '1 : mag[SAMPLE_W-2 -: LEVEL_W];
	assign pk = (lvl_new > peak_q) ? lvl_new : peak_q;

	// column step: quotient 0 or 1 handled here, anything else by the divider
	assign step = STEP_W'(rem_q) + STEP_W'(cfg.cols);
	assign len_x = STEP_W'(cfg.len);
	assign fast0 = step < len_x;
	assign step_m = step - len_x;
	assign fast = fast0 || (step_m < len_x);
	assign fq = fast0 ? '0 : STEP_W'(1);
	assign fr = fast0 ? step[LENGTH_BITS-1:0] : step_m[LENGTH_BITS-1:0];

	assign q_sel = (state_q == ST_FIN) ? div_quo : fq;
	assign r_sel = (state_q == ST_FIN) ? div_rem : fr;
	assign ci_sel = (state_q == ST_FIN) ? ci_q : ci;
	assign pk_sel = (state_q == ST_FIN) ? pk_q : pk;
	assign nsum = (STEP_W+1)'(ci_sel) + (STEP_W+1)'(q_sel);
	assign nxt = (nsum > (STEP_W+1)'(cols_m1)) ? cols_m1 : nsum[COL_W-1:0];

	// completion handshake with the output register
	assign slot_free = !out_valid_q || !out_stall;
	assign commit = slot_free && (((state_q == ST_ENV) && (!cols_on || fast))
		|| (state_q == ST_FIN));
	assign env_upd = commit && cols_on;
	assign div_start = (state_q == ST_ENV) && cols_on && !fast;

	spf_div u_div (
		.clk(clk),
		.arst_n(arst_n),
		.start(div_start),
		.dividend(step),
		.divisor(cfg.len),
		.busy(div_busy),
		.quotient(div_quo),
		.remainder(div_rem)
	);

	// datapath registers
	always_ff @(posedge clk) begin
		if (pop) begin
			diff_q <= diff;
			gw_q <= gw;
			eot_q <= head.eot;
			if (!head.filt) begin
				res_q <= head.sample;
			end
		end
		if (state_q == ST_HP) begin
			y_q <= y_sat;
		end
		if (state_q == ST_COMP) begin
			comp_q <= comp;
		end
		if (state_q == ST_SCALE) begin
			num_q <= num;
		end
		if (state_q == ST_ROUND) begin
			res_q <= res_sat;
		end
		if (div_start) begin
			ci_q <= ci;
			pk_q <= pk;
		end
	end

	// filter and envelope state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_in_q <= '0;
			prev_out_q <= '0;
			d1_q <= '0;
			d2_q <= '0;
			primed_q <= 1'b0;
			col_q <= '0;
			rem_q <= '0;
			peak_q <= '0;
		end else begin
			if (pop) begin
				if (head.first) begin
					prev_out_q <= '0;
					d1_q <= '0;
					d2_q <= '0;
					col_q <= '0;
					rem_q <= '0;
					peak_q <= '0;
				end
				// a filtered sample seeds the filter, a raw first sample only restarts it
				if (head.filt) begin
					primed_q <= 1'b1;
					prev_in_q <= head.sample;
				end else if (head.first) begin
					primed_q <= 1'b0;
					prev_in_q <= '0;
				end
			end
			if (state_q == ST_COMP) begin
				prev_out_q <= y_q;
				d2_q <= d1_q;
				d1_q <= y_q;
			end
			if (env_upd) begin
				col_q <= nxt;
				rem_q <= r_sel;
				peak_q <= (nxt != ci_sel) ? '0 : pk_sel;
			end
		end
	end

	// sequencer and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			out_valid_q <= 1'b0;
			out_sample_q <= '0;
			env_column_q <= '0;
			env_level_q <= '0;
			end_of_take_q <= 1'b0;
		end else begin
			if (commit) begin
				out_valid_q <= 1'b1;
				out_sample_q <= res_q;
				env_column_q <= cols_on ? ci_sel : '0;
				env_level_q <= cols_on ? pk_sel : '0;
				end_of_take_q <= eot_q;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: if (pop) begin
					state_q <= head.filt ? ST_HP : ST_ENV;
				end
				ST_HP: begin
					state_q <= ST_COMP;
				end
				ST_COMP: begin
					state_q <= ST_SCALE;
				end
				ST_SCALE: begin
					state_q <= ST_ROUND;
				end
				ST_ROUND: begin
					state_q <= ST_ENV;
				end
				ST_ENV: if (commit) begin
					state_q <= ST_IDLE;
				end else if (div_start) begin
					state_q <= ST_DIV;
				end
				ST_DIV: if (!div_busy) begin
					state_q <= ST_FIN;
				end
				ST_FIN: if (commit) begin
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

@@ rtl/speech_post_filter_gain_fade.sv @@
`default_nettype none

// Speech post filter for a trimmed take: each sample goes through a DC-blocking
// high-pass, a 3-tap droop compensator, the configured gain and a linear fade
// in and out, then is rounded half to even and saturated to 16 bits; takes
// shorter than two fade lengths pass through raw. Each result also carries its
// envelope column, the running peak of that column and an end-of-take flag.
// A four-entry queue separates the input side, which counts samples and works
// out fade weights, from a sequencer that does the arithmetic. The sequencer
// steps a filtered sample through difference, filter multiply, compensator,
// gain times fade multiply, rounding and envelope steps; a raw one goes
// straight to the envelope step. When the column step reaches twice the take
// length or more (more columns than samples, or a shortened take), the column
// advance goes through a bit-serial divider before that sample completes.
// Registers may be written only while no sample is in flight.
module speech_post_filter_gain_fade
	import spf_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_stall,
	input wire logic signed [SAMPLE_W-1:0] sample,
	input wire logic first,
	output logic out_valid,
	input wire logic out_stall,
	output logic signed [SAMPLE_W-1:0] out_sample,
	output logic [COL_W-1:0] env_column,
	output logic [LEVEL_W-1:0] env_level,
	output logic end_of_take,
	input wire logic cfg_valid,
	output logic cfg_ready,
	input wire logic [CFG_IDX_W-1:0] cfg_index,
	input wire logic [CFG_DATA_W-1:0] cfg_data
);

	logic [GAIN_W-1:0] gain_q;
	logic [LENGTH_BITS-1:0] length_q;
	logic [COLS_W-1:0] columns_q;
	spf_cfg_t cfg;
	logic push;
	spf_item_t push_item;
	logic q_full;
	logic q_empty;
	logic pop;
	spf_item_t head;

	assign cfg_ready = 1'b1;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q <= GAIN_W'(4096);
			length_q <= LENGTH_BITS'(1);
			columns_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_GAIN: begin
					gain_q <= cfg_data[GAIN_W-1:0];
				end
				REG_LENGTH: begin
					length_q <= cfg_data[LENGTH_BITS-1:0];
				end
				REG_COLUMNS: begin
					columns_q <= cfg_data[COLS_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	// clamp gain and columns, zero length counts as one
	always_comb begin
		cfg.gain = (gain_q > GAIN_W'(GAIN_MAX_Q12)) ? GAIN_W'(GAIN_MAX_Q12) : gain_q;
		cfg.len = (length_q == '0) ? LENGTH_BITS'(1) : length_q;
		cfg.cols = (columns_q > COLS_W'(MAX_COLUMNS)) ? COLS_W'(MAX_COLUMNS) : columns_q;
	end

	spf_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.sample(sample),
		.first(first),
		.cfg(cfg),
		.q_full(q_full),
		.push(push),
		.push_item(push_item)
	);

	spf_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.push_item(push_item),
		.pop(pop),
		.full(q_full),
		.empty(q_empty),
		.head(head)
	);

	spf_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg),
		.q_empty(q_empty),
		.head(head),
		.pop(pop),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_sample(out_sample),
		.env_column(env_column),
		.env_level(env_level),
		.end_of_take(end_of_take)
	);

endmodule

`default_nettype wire
